@@ sv/ksd_pkg.sv @@
package ksd_pkg;

   typedef logic [3:0] row_lines_type;
   typedef logic [1:0] column_type;
   typedef logic [3:0] key_code_type;
   typedef logic [7:0] count_type;

   localparam count_type ThresholdReset = 8'd20;
   localparam int        RowCount       = 4;

endpackage

@@ sv/ksd_req_if.sv @@
interface ksd_req_if;

   logic                   valid;
   logic                   ready;
   ksd_pkg::row_lines_type row_lines;

   modport source (output valid, output row_lines, input ready);
   modport sink   (input valid, input row_lines, output ready);

endinterface

@@ sv/ksd_rsp_if.sv @@
interface ksd_rsp_if;

   logic                  valid;
   logic                  ready;
   ksd_pkg::column_type   column_drive;
   ksd_pkg::key_code_type key_code;
   logic                  key_valid;

   modport source (output valid, output column_drive, output key_code, output key_valid,
                   input ready);
   modport sink   (input valid, input column_drive, input key_code, input key_valid,
                   output ready);

endinterface

@@ sv/keypad_scan_count_debounce.sv @@
// 4x4 keypad scanner with press-count debounce.
// req_if carries one row sample (active low, bit 0 = row 3) per scan tick,
// taken while the previously returned column_drive was applied to the matrix.
// rsp_if returns one transfer per sample: the column to drive next, and when
// enough key-detecting passes have gone by, the key code with key_valid set.
// csr_we/csr_wdata write the press threshold (reset value 20); write it only
// while no sample is in flight.
// A sample accepted on req_if passes the input register, then the result
// register, before it shows on rsp_if. Throughput: one sample per cycle
// while rsp_if does not stall; the column and press counter update is
// combinational between the two registers.
// Reset (synchronous, active high) empties both registers, resets the scan
// column to 0, clears the press counter and loads the default threshold.
// When rsp_if stalls, the result register holds; the input register still
// takes one more sample, and req_if.ready drops once both are full.
module keypad_scan_count_debounce (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [7:0]    csr_wdata,
   ksd_req_if.sink       req_if,
   ksd_rsp_if.source     rsp_if
);

   logic                   in_valid_ff, in_valid_in;
   ksd_pkg::row_lines_type in_rows_ff, in_rows_in;
   logic                   out_valid_ff, out_valid_in;
   ksd_pkg::column_type    out_column_ff, out_column_in;
   ksd_pkg::key_code_type  out_code_ff, out_code_in;
   logic                   out_key_valid_ff, out_key_valid_in;
   ksd_pkg::column_type    scan_column_ff, scan_column_in;
   ksd_pkg::count_type     press_count_ff, press_count_in;
   ksd_pkg::count_type     threshold_ff, threshold_in;

   logic                   advance;
   logic                   found;
   logic [1:0]             row;
   ksd_pkg::count_type     count_inc;
   logic                   report;

   assign advance      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = !in_valid_ff || advance;

   // lowest low bit wins, so scan from the top down and let lower bits override
   always_comb begin
      found = 1'b0;
      row   = 2'd0;
      for (int b = ksd_pkg::RowCount - 1; b >= 0; b--) begin
         if (!in_rows_ff[b]) begin
            found = 1'b1;
            row   = 2'(ksd_pkg::RowCount - 1 - b);
         end
      end
   end

   assign count_inc = press_count_ff + 8'd1;
   assign report    = found && (count_inc >= threshold_ff);

   always_comb begin
      in_valid_in      = in_valid_ff;
      in_rows_in       = in_rows_ff;
      out_valid_in     = out_valid_ff;
      out_column_in    = out_column_ff;
      out_code_in      = out_code_ff;
      out_key_valid_in = out_key_valid_ff;
      scan_column_in   = scan_column_ff;
      press_count_in   = press_count_ff;
      threshold_in     = csr_we ? csr_wdata : threshold_ff;

      if (req_if.ready) begin
         in_valid_in = req_if.valid;
         in_rows_in  = req_if.row_lines;
      end

      if (advance) begin
         out_valid_in = in_valid_ff;
         if (in_valid_ff) begin
            if (found) begin
               // key seen: restart the pass at column 0 and count it
               scan_column_in = 2'd0;
               press_count_in = report ? 8'd0 : count_inc;
            end else begin
               scan_column_in = scan_column_ff + 2'd1;
            end
            out_column_in    = found ? 2'd0 : scan_column_ff + 2'd1;
            out_code_in      = report ? {scan_column_ff, row} : 4'd0;
            out_key_valid_in = report;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         scan_column_ff <= 2'd0;
         press_count_ff <= 8'd0;
         threshold_ff   <= ksd_pkg::ThresholdReset;
      end else begin
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         scan_column_ff <= scan_column_in;
         press_count_ff <= press_count_in;
         threshold_ff   <= threshold_in;
      end
   end

   always_ff @(posedge clock) begin
      in_rows_ff       <= in_rows_in;
      out_column_ff    <= out_column_in;
      out_code_ff      <= out_code_in;
      out_key_valid_ff <= out_key_valid_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.column_drive = out_column_ff;
   assign rsp_if.key_code     = out_code_ff;
   assign rsp_if.key_valid    = out_key_valid_ff;

endmodule
